FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker tea_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define TEA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define TEA_ASSERT_NEXT(lbl, clk, rst_n, cond, res, msg) \
	`TEA_ASSERT(lbl, clk, rst_n, (cond) |=> (res), msg)

`endif

FILE: rtl/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

	localparam int ROUND_COUNT_DEF = 32;
	localparam int WORD_W          = 32;
	localparam int KEY_COUNT       = 4;
	localparam int CFG_INDEX_W     = 3;

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} tea_op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_WORD0 = 3'd0,
		REG_KEY_WORD1 = 3'd1,
		REG_KEY_WORD2 = 3'd2,
		REG_KEY_WORD3 = 3'd3
	} tea_reg_t;

	typedef struct packed {
		logic              op;
		logic [WORD_W-1:0] half_first;
		logic [WORD_W-1:0] half_second;
	} tea_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_first;
		logic [WORD_W-1:0] out_second;
	} tea_res_t;

	// delta * n mod 2^32, only called with elaboration-time constants
	function automatic logic [WORD_W-1:0] tea_sum(input int n);
		logic [2*WORD_W-1:0] p;
		p = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(n);
		return p[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] tea_mix(
		input logic [WORD_W-1:0] h,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		return ((h << 4) + ka) ^ (h + s) ^ ((h >> 5) + kb);
	endfunction

endpackage

FILE: rtl/tea_block_cipher.sv
`timescale 1ns / 1ps

// TEA block cipher, 64-bit block, 128-bit key from four key registers.
// Each request carries op (encrypt or decrypt) and the two block words; each
// gives exactly one result. The rounds are unrolled into 2*ROUND_COUNT
// register stages, one half-round (one word update) per stage, and one block
// is accepted per cycle unless the output stalls. The whole pipe holds while a
// result sits stalled on the output; req_stall is high exactly then. Key
// writes are to be made with no request in flight; writes to an index past
// key_word3 are dropped.
module tea_block_cipher
	import tea_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  tea_req_t               req,
	output logic                   res_valid,
	input  logic                   res_stall,
	output tea_res_t               res
);

	localparam int STAGES = 2 * ROUND_COUNT;

	logic [WORD_W-1:0] key_q [KEY_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_COUNT; i++) key_q[i] <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KEY_WORD0: key_q[0] <= cfg_data;
				REG_KEY_WORD1: key_q[1] <= cfg_data;
				REG_KEY_WORD2: key_q[2] <= cfg_data;
				REG_KEY_WORD3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// index 0 is the incoming request, 1..STAGES are pipeline registers
	logic              vld_s [STAGES+1];
	tea_op_t           op_s  [STAGES+1];
	logic [WORD_W-1:0] x_s   [STAGES+1];
	logic [WORD_W-1:0] y_s   [STAGES+1];

	logic advance;

	assign advance   = !(vld_s[STAGES] && res_stall);
	assign req_stall = !advance;

	assign vld_s[0] = req_valid;
	assign op_s[0]  = tea_op_t'(req.op);
	assign x_s[0]   = req.half_first;
	assign y_s[0]   = req.half_second;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam int RND = i / 2;
		localparam logic [WORD_W-1:0] SUM_ENC = tea_sum(RND + 1);
		localparam logic [WORD_W-1:0] SUM_DEC = tea_sum(ROUND_COUNT - RND);
		localparam logic ODD = 1'((i % 2) != 0);

		logic              upd_x;
		logic [WORD_W-1:0] src, tgt, ka, kb, sum, mix, nxt;

		// encrypt: even stages update x, odd update y; decrypt the reverse
		always_comb begin
			upd_x = (op_s[i] == OP_DECRYPT) ? ODD : !ODD;
			src   = upd_x ? y_s[i] : x_s[i];
			tgt   = upd_x ? x_s[i] : y_s[i];
			ka    = upd_x ? key_q[0] : key_q[2];
			kb    = upd_x ? key_q[1] : key_q[3];
			sum   = (op_s[i] == OP_DECRYPT) ? SUM_DEC : SUM_ENC;
			mix   = tea_mix(src, sum, ka, kb);
			nxt   = (op_s[i] == OP_DECRYPT) ? tgt - mix : tgt + mix;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (advance) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				op_s[i+1] <= op_s[i];
				x_s[i+1]  <= upd_x ? nxt : x_s[i];
				y_s[i+1]  <= upd_x ? y_s[i] : nxt;
			end
		end
	end

	assign res_valid      = vld_s[STAGES];
	assign res.out_first  = x_s[STAGES];
	assign res.out_second = y_s[STAGES];

endmodule

FILE: rtl/tea_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tea_chk
	import tea_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_stall,
	input logic     res_valid,
	input logic     res_stall,
	input tea_res_t res
);

	// held result stays put
	`TEA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

	// a held result freezes the pipe, so no request may enter
	`TEA_ASSERT(a_stall_on_hold, clk, arst_n, (res_valid && res_stall) |-> req_stall, "request taken while output held")

	// the input is only pushed back by a held result
	`TEA_ASSERT(a_stall_cause, clk, arst_n, req_stall |-> (res_valid && res_stall), "input stalled with output free")

endmodule

bind tea_block_cipher tea_chk u_tea_chk (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tea_pkg::*;

	localparam int ROUNDS       = ROUND_COUNT_DEF;
	localparam int DRAIN_CYCLES = 2 * ROUNDS + 8;
	localparam int CHUNK_ITEMS  = 115;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;

	localparam tea_reg_t KEY_REGS[KEY_COUNT] = '{
		REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3
	};

	class cipher_checker;
		logic [WORD_W-1:0] key[KEY_COUNT];
		tea_res_t          expected_blocks[$];
		int unsigned       errors;

		function new();
			foreach (key[i]) key[i] = '0;
			errors = 0;
		endfunction

		function void set_key(int idx, logic [WORD_W-1:0] val);
			key[idx] = val;
		endfunction

		function logic [WORD_W-1:0] round_mix(logic [WORD_W-1:0] h, logic [WORD_W-1:0] s,
				logic [WORD_W-1:0] ka, logic [WORD_W-1:0] kb);
			return ((h << 4) + ka) ^ (h + s) ^ ((h >> 5) + kb);
		endfunction

		function tea_res_t tea_transform(tea_req_t r);
			logic [WORD_W-1:0] x, y, s;
			tea_res_t o;
			x = r.half_first;
			y = r.half_second;
			s = '0;
			if (r.op == OP_ENCRYPT) begin
				for (int n = 0; n < ROUNDS; n++) begin
					s += TEA_DELTA;
					x += round_mix(y, s, key[0], key[1]);
					y += round_mix(x, s, key[2], key[3]);
				end
			end else begin
				// decrypt starts from the sum the last encrypt round reached
				repeat (ROUNDS) s += TEA_DELTA;
				for (int n = 0; n < ROUNDS; n++) begin
					y -= round_mix(x, s, key[2], key[3]);
					x -= round_mix(y, s, key[0], key[1]);
					s -= TEA_DELTA;
				end
			end
			o.out_first  = x;
			o.out_second = y;
			return o;
		endfunction

		function void note_request(tea_req_t r);
			expected_blocks.push_back(tea_transform(r));
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s", $time, msg);
		endfunction

		function void check_result(tea_res_t got);
			tea_res_t want;
			if (expected_blocks.size() == 0) begin
				flag($sformatf("result %h %h with no request outstanding",
					got.out_first, got.out_second));
				return;
			end
			want = expected_blocks.pop_front();
			if (got.out_first !== want.out_first)
				flag($sformatf("out_first: expected %h, got %h", want.out_first, got.out_first));
			if (got.out_second !== want.out_second)
				flag($sformatf("out_second: expected %h, got %h",
					want.out_second, got.out_second));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data = '0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	tea_req_t               req = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	tea_res_t               res;

	int unsigned recv_idle_pct = 0;
	int unsigned send_idle_pct = 0;
	logic        hold_request = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned hold_left = 0;

	cipher_checker sb;

	tea_block_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: check, then pick next stall (random, or one long hold-off)
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			sb.check_result(res);
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			res_stall <= 1'b1;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic tea_req_t make_req(tea_op_t op, logic [WORD_W-1:0] a,
			logic [WORD_W-1:0] b);
		tea_req_t r;
		r.op          = op;
		r.half_first  = a;
		r.half_second = b;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] one_hot;
		one_hot = WORD_W'(1) << $urandom_range(WORD_W - 1);
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_block(input tea_req_t r);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic send_op(input tea_op_t op, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		send_block(make_req(op, a, b));
	endtask

	// encrypt a block, then send its ciphertext back for decryption
	task automatic send_round_trip(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		tea_res_t c;
		c = sb.tea_transform(make_req(OP_ENCRYPT, a, b));
		send_op(OP_ENCRYPT, a, b);
		send_op(OP_DECRYPT, c.out_first, c.out_second);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
			input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
		logic [WORD_W-1:0] k[KEY_COUNT];
		k = '{k0, k1, k2, k3};
		for (int i = 0; i < KEY_COUNT; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= KEY_REGS[i];
			cfg_data  <= k[i];
			sb.set_key(i, k[i]);
			@(posedge clk);
		end
		// indexes past the last key word must be dropped
		for (int i = KEY_COUNT; i < (1 << CFG_INDEX_W); i++) begin
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data  <= $urandom;
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_random_key();
		logic [WORD_W-1:0] k[KEY_COUNT];
		int unsigned mode;
		mode = $urandom_range(3);
		foreach (k[i]) begin
			case (mode)
				0: k[i] = $urandom;
				1: k[i] = '0;
				2: k[i] = '1;
				default: k[i] = pick_word();
			endcase
		end
		load_key(k[0], k[1], k[2], k[3]);
	endtask

	task automatic run_chunk(input int count);
		tea_req_t r;
		tea_res_t prev_out;
		tea_op_t  prev_op;
		bit       have_prev;
		have_prev = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (have_prev && $urandom_range(4) == 0) begin
				// feed the last output back with the opposite op
				if (prev_op == OP_ENCRYPT)
					r = make_req(OP_DECRYPT, prev_out.out_first, prev_out.out_second);
				else
					r = make_req(OP_ENCRYPT, prev_out.out_first, prev_out.out_second);
			end else begin
				r = make_req(tea_op_t'($urandom_range(1)), pick_word(), pick_word());
			end
			prev_out  = sb.tea_transform(r);
			prev_op   = tea_op_t'(r.op);
			have_prev = 1'b1;
			send_block(r);
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key never written: all-zero key
		send_op(OP_ENCRYPT, '0, '0);
		send_op(OP_DECRYPT, '0, '0);
		send_op(OP_ENCRYPT, '1, '1);
		send_op(OP_DECRYPT, '1, '1);
		send_op(OP_ENCRYPT, '0, '1);
		send_op(OP_DECRYPT, '1, '0);
		send_op(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		send_op(OP_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
		send_round_trip('0, '0);
		wait_drained();

		load_key('1, '1, '1, '1);
		send_op(OP_ENCRYPT, '0, '0);
		send_op(OP_DECRYPT, '0, '0);
		send_op(OP_ENCRYPT, '1, '1);
		send_op(OP_DECRYPT, '1, '1);
		send_round_trip(32'h0123_4567, 32'h89ab_cdef);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct <= 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct <= 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			for (int c = 0; c < 3; c++) begin
				load_random_key();
				if (p == 2 && c == 0)
					hold_request <= 1'b1;
				run_chunk(CHUNK_ITEMS);
				wait_drained();
			end
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: tea_block_cipher.f
+incdir+rtl
rtl/tea_pkg.sv
rtl/tea_block_cipher.sv
rtl/tea_chk.sv
tb/testbench.sv
